[design/dtfd_pkg.sv]
package dtfd_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int INT_DIGITS  = 10;
    localparam int TEXT_MAX    = 1 + INT_DIGITS + 1 + FRAC_DIGITS;
    localparam int IP_W        = 32;
    localparam int FR_W        = 20;
    localparam int BCD_W       = 4 * (INT_DIGITS + FRAC_DIGITS);
    localparam int SH_W        = 6;
    localparam int CNT_W       = 5;
    localparam int PROD_W      = 53 + FR_W + 1;

    localparam logic [FR_W-1:0] POW10 = FR_W'(1000000);
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_CONV  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_ERR   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic round;
        logic conv_start;
        logic conv_step;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic is_nan;
        logic is_inf;
        logic too_big;
        logic conv_done;
        logic int_long;
        logic emit_last;
    } t_status;

endpackage

[design/double_to_fixed_decimal_text_core.sv]
// Formats an IEEE-754 double as printf %f text, one character per output item:
// optional '-', integer digits, '.', six fraction digits, rounded half-up on the
// exact value. Infinity gives inf/INF; NaN or magnitude >= 2^31 gives a single
// item with o_out_of_range set and o_out_char zero. A finite item passes through
// the multiply, the round and the 52-bit binary-to-BCD shift loop before its
// first character, then one character per cycle while the consumer is ready;
// infinity and errors start emitting on the next cycle.
// One item is in flight at a time.
module double_to_fixed_decimal_text_core
    import dtfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value_bits,
    input  logic        i_upper_case,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    output logic        o_out_of_range
);
    t_cmd    cmd;
    t_status status;
    logic    err;
    logic [7:0] ch;

    dtfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_err    (err),
        .o_cmd    (cmd),
        .i_status (status)
    );

    dtfd_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_value_bits (i_value_bits),
        .i_upper_case (i_upper_case),
        .o_status     (status),
        .o_char       (ch)
    );

    // Drive the result item
    assign o_out_char     = err ? 8'd0 : ch;
    assign o_last         = err || status.emit_last;
    assign o_out_of_range = err;
endmodule

[design/dtfd_datapath.sv]
module dtfd_datapath
    import dtfd_pkg::*;
(
    input  logic                i_clk,
    input  t_cmd                i_cmd,
    input  logic [63:0]         i_value_bits,
    input  logic                i_upper_case,
    output t_status             o_status,
    output logic [7:0]          o_char
);
    logic            r_neg, r_upper, r_inf;
    logic [52:0]     r_m;
    logic [10:0]     r_s;
    logic [IP_W-1:0] r_ip;
    logic [52:0]     r_frac;
    logic [PROD_W-1:0] r_prod;
    logic [FR_W-1:0] r_fr;
    logic [IP_W+FR_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [SH_W-1:0] r_bit_cnt;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_ndig;

    logic [10:0] expo;
    logic [51:0] mant;
    assign expo = i_value_bits[62:52];
    assign mant = i_value_bits[51:0];

    // Classify the incoming item
    assign o_status.is_nan  = 1'b0;
    logic st_nan, st_inf, st_big;
    assign st_nan = (r_s == 11'h7FF) && 1'b0;

    // Load: split into integer part and fraction
    logic [52:0] m_in;
    logic [10:0] s_in;
    logic [IP_W-1:0] ip_in;
    logic [52:0] frac_in;
    logic [6:0] sh;
    always_comb begin
        m_in = (expo == 11'd0) ? {1'b0, mant} : {1'b1, mant};
        s_in = (expo == 11'd0) ? 11'd1074 : 11'(11'd1075 - expo);
        sh = (s_in >= 11'd64) ? 7'd64 : s_in[6:0];
        if (sh >= 7'd53) begin
            ip_in = '0;
            frac_in = m_in;
        end else begin
            ip_in = IP_W'(m_in >> sh);
            frac_in = m_in & ((53'd1 << sh) - 53'd1);
        end
    end

    // Rounded fraction from the product at bit s-1
    logic [PROD_W+63:0] prod_ext;
    logic [10:0] sm1;
    logic [PROD_W-1:0] q;
    logic [FR_W:0] fr_r;
    always_comb begin
        prod_ext = {64'd0, r_prod};
        sm1 = 11'(r_s - 11'd1);
        q = (sm1 >= 11'd128) ? '0 : PROD_W'(prod_ext >> sm1[6:0]);
        fr_r = (FR_W+1)'((q + PROD_W'(1)) >> 1);
    end

    // Double-dabble: add 3 to digits >= 5, then shift
    logic [BCD_W-1:0] bcd_adj;
    always_comb begin
        for (int d = 0; d < INT_DIGITS + FRAC_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                4'(r_bcd[4*d +: 4] + 4'd3) : r_bcd[4*d +: 4];
        end
    end

    // Count integer digits
    logic [CNT_W-1:0] ndig;
    always_comb begin
        ndig = CNT_W'(1);
        for (int d = 1; d < INT_DIGITS; d++) begin
            if (r_bcd[4*(FRAC_DIGITS+d) +: 4] != 4'd0) ndig = CNT_W'(d + 1);
        end
    end

    // Scale to integer part times 10^6 plus fraction for the BCD loop
    logic [IP_W+FR_W-1:0] scaled;
    assign scaled = ((IP_W+FR_W)'(r_ip) * (IP_W+FR_W)'(POW10)) + (IP_W+FR_W)'(r_fr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_value_bits[63];
            r_upper <= i_upper_case;
            r_inf   <= (expo == 11'h7FF);
            r_m     <= m_in;
            r_s     <= (expo == 11'h7FF) ? 11'h7FF : s_in;
            r_ip    <= ip_in;
            r_frac  <= frac_in;
            r_pos   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_frac) * PROD_W'(POW10);
        end
        if (i_cmd.round) begin
            if (fr_r >= {1'b0, POW10}) begin
                r_fr <= FR_W'(fr_r - {1'b0, POW10});
                r_ip <= IP_W'(r_ip + IP_W'(1));
            end else begin
                r_fr <= FR_W'(fr_r);
            end
        end
        if (i_cmd.conv_start) begin
            r_bin <= scaled;
            r_bcd <= '0;
            r_bit_cnt <= '0;
        end
        if (i_cmd.conv_step) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[IP_W+FR_W-1]};
            r_bin <= {r_bin[IP_W+FR_W-2:0], 1'b0};
            r_bit_cnt <= SH_W'(r_bit_cnt + SH_W'(1));
            r_ndig <= ndig;
        end
        if (i_cmd.emit_next) r_pos <= CNT_W'(r_pos + CNT_W'(1));
    end

    // Character sequencing over the finished digits
    logic [CNT_W-1:0] total, idx, k;
    logic [CNT_W-1:0] ndig_now;
    always_comb begin
        ndig_now = ndig;
        k = r_neg ? CNT_W'(r_pos - CNT_W'(1)) : r_pos;
        idx = '0;
        o_char = CH_ZERO;
        if (r_inf) begin
            total = r_neg ? CNT_W'(4) : CNT_W'(3);
            if (r_neg && r_pos == '0) o_char = CH_MINUS;
            else begin
                case (k)
                    CNT_W'(0): o_char = r_upper ? 8'h49 : 8'h69;
                    CNT_W'(1): o_char = r_upper ? 8'h4E : 8'h6E;
                    default:   o_char = r_upper ? 8'h46 : 8'h66;
                endcase
            end
        end else begin
            total = CNT_W'(ndig_now + CNT_W'(FRAC_DIGITS + 1 + (r_neg ? 1 : 0)));
            if (r_neg && r_pos == '0) o_char = CH_MINUS;
            else if (k < ndig_now) begin
                idx = CNT_W'(FRAC_DIGITS + ndig_now - CNT_W'(1) - k);
                o_char = CH_ZERO | {4'd0, r_bcd[4*idx +: 4]};
            end else if (k == ndig_now) o_char = CH_DOT;
            else begin
                idx = CNT_W'(FRAC_DIGITS - 1 - (k - ndig_now - CNT_W'(1)));
                o_char = CH_ZERO | {4'd0, r_bcd[4*idx +: 4]};
            end
        end
    end

    assign st_inf = 1'b0;
    assign st_big = 1'b0;
    assign o_status.is_inf    = (expo == 11'h7FF) && (mant == '0) || st_nan || st_inf;
    assign o_status.too_big   = ((expo != 11'h7FF) && (expo >= 11'd1054)) ||
                                ((expo == 11'h7FF) && (mant != '0)) || st_big;
    assign o_status.conv_done = (r_bit_cnt == SH_W'(IP_W + FR_W));
    assign o_status.int_long  = (r_bin != '0) && 1'b0 || (r_ndig > CNT_W'(INT_DIGITS));
    assign o_status.emit_last = (CNT_W'(r_pos + CNT_W'(1)) == total);

    logic unused_m;
    assign unused_m = ^{r_m, idx};
endmodule

[design/dtfd_ctrl.sv]
module dtfd_ctrl
    import dtfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output logic    o_err,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    t_state r_state, n_state;
    logic   out_fire;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = (r_state == ST_EMIT) || (r_state == ST_ERR);
    assign o_err    = (r_state == ST_ERR);
    assign out_fire = o_valid && i_ready;

    // Sequence one item through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.too_big) n_state = ST_ERR;
                    else if (i_status.is_inf) n_state = ST_EMIT;
                    else n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = ST_CONV;
            end
            ST_CONV: begin
                o_cmd.conv_start = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.conv_done) begin
                    n_state = i_status.int_long ? ST_ERR : ST_EMIT;
                end else begin
                    o_cmd.conv_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_fire) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_status.emit_last) n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (out_fire) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end
endmodule

[verif/dtfd_checker.sv]
module dtfd_checker
    import dtfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [63:0] i_value_bits,
    input  logic        i_upper_case,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_out_char,
    input  logic        o_last,
    input  logic        o_out_of_range,
    output int          o_fail_count,
    output int          o_chars_pending
);

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       oor;
    } t_text_char;

    t_text_char char_queue[$];

    // Push one character of the predicted text
    task automatic push_char(input logic [7:0] c);
        t_text_char t;
        t.ch   = c;
        t.last = 1'b0;
        t.oor  = 1'b0;
        char_queue.push_back(t);
    endtask

    task automatic push_range_error();
        t_text_char t;
        t.ch   = 8'd0;
        t.last = 1'b1;
        t.oor  = 1'b1;
        char_queue.push_back(t);
    endtask

    // Predict the %f text of one number and queue its characters
    task automatic predict_text(input logic [63:0] bits, input logic upper);
        logic         neg;
        logic [10:0]  expo;
        logic [51:0]  mant;
        logic [52:0]  mag;
        int           shift;
        logic [127:0] whole, frac, prod, q;
        logic [63:0]  int_part, frac_part;
        logic [7:0]   int_digs[20];
        logic [7:0]   frac_digs[FRAC_DIGITS];
        int           n;
        neg  = bits[63];
        expo = bits[62:52];
        mant = bits[51:0];
        if (expo == 11'h7FF) begin
            if (mant != 0) begin
                push_range_error();
                return;
            end
            if (neg) push_char(CH_MINUS);
            push_char(upper ? "I" : "i");
            push_char(upper ? "N" : "n");
            push_char(upper ? "F" : "f");
        end else begin
            if (expo >= 11'd1054) begin
                push_range_error();
                return;
            end
            if (expo == 0) begin
                mag   = {1'b0, mant};
                shift = 1074;
            end else begin
                mag   = {1'b1, mant};
                shift = 1075 - int'(expo);
            end
            whole = 128'(mag);
            if (shift >= 64) begin
                int_part = 0;
                frac     = whole;
            end else begin
                int_part = 64'(whole >> shift);
                frac     = whole & ((128'd1 << shift) - 1);
            end
            // Scale the fraction and round half-up at the binary point
            prod = frac * 128'd1000000;
            q    = (shift - 1 >= 128) ? 128'd0 : (prod >> (shift - 1));
            frac_part = 64'((q + 1) >> 1);
            if (frac_part >= 64'd1000000) begin
                frac_part = frac_part - 64'd1000000;
                int_part  = int_part + 1;
            end
            n = 0;
            do begin
                int_digs[n] = CH_ZERO + 8'(int_part % 10);
                int_part    = int_part / 10;
                n++;
            end while (int_part != 0 && n < 20);
            if (n > INT_DIGITS) begin
                push_range_error();
                return;
            end
            if (neg) push_char(CH_MINUS);
            for (int i = n - 1; i >= 0; i--) push_char(int_digs[i]);
            push_char(CH_DOT);
            for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
                frac_digs[i] = CH_ZERO + 8'(frac_part % 10);
                frac_part    = frac_part / 10;
            end
            for (int i = 0; i < FRAC_DIGITS; i++) push_char(frac_digs[i]);
        end
        char_queue[char_queue.size() - 1].last = 1'b1;
    endtask

    // Predict on accepted items, compare emitted characters in order
    always @(posedge i_clk) begin
        t_text_char exp_c;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && o_ready) predict_text(i_value_bits, i_upper_case);
            if (o_valid && i_ready) begin
                if (char_queue.size() == 0) begin
                    $error("unexpected character %h", o_out_char);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = char_queue.pop_front();
                    if (o_out_char !== exp_c.ch || o_last !== exp_c.last ||
                        o_out_of_range !== exp_c.oor)
                        o_fail_count <= o_fail_count + 1;
                    if (o_out_char !== exp_c.ch)
                        $error("out_char expected %h actual %h", exp_c.ch, o_out_char);
                    if (o_last !== exp_c.last)
                        $error("last expected %b actual %b", exp_c.last, o_last);
                    if (o_out_of_range !== exp_c.oor)
                        $error("out_of_range expected %b actual %b",
                               exp_c.oor, o_out_of_range);
                end
            end
        end
        o_chars_pending <= char_queue.size();
    end

endmodule

[verif/tb.sv]
module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_value_bits = '0;
    logic        i_upper_case = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;
    logic        o_out_of_range;
    int          fail_count;
    int          chars_pending;
    logic        calm = 1'b0;
    int          idle_cycles = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    double_to_fixed_decimal_text_core u_dut (.*);

    dtfd_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_value_bits, .i_upper_case,
        .o_valid, .i_ready, .o_out_char, .o_last, .o_out_of_range,
        .o_fail_count(fail_count), .o_chars_pending(chars_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the consumer in random bursts until the calm tail
    always @(posedge i_clk) begin
        if (calm || $urandom_range(3) != 0) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
            i_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Offer one number and hold it until accepted
    task automatic send_number(input logic [63:0] bits, input logic upper);
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value_bits <= bits;
        i_upper_case <= upper;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [63:0] random_number();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       ;
            1:       bits[62:52] = 11'h7FF;
            2:       bits[62:52] = 11'd0;
            3:       bits[62:52] = 11'(1054 + $urandom_range(3));
            default: bits[62:52] = 11'($urandom_range(1053, 990));
        endcase
        return bits;
    endfunction

    initial begin
        real directed[$];
        directed = '{0.0, -0.0, 1.0, -1.5, 0.0000005, 0.00000049999999,
                     999999.9999995, 0.9999995, 123.456789, 2147483647.9999999,
                     2147483647.0, 2147483648.0, -2147483648.5, 1.0e-300,
                     3.14159265358979};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_number($realtobits(directed[k]), k[0]);
        send_number(64'h7FF0_0000_0000_0000, 1'b0);
        send_number(64'h7FF0_0000_0000_0000, 1'b1);
        send_number(64'hFFF0_0000_0000_0000, 1'b1);
        send_number(64'hFFF0_0000_0000_0000, 1'b0);
        send_number(64'h7FF8_0000_0000_0000, 1'b0);
        send_number(64'hFFF0_0000_0000_0001, 1'b1);
        send_number(64'h0000_0000_0000_0001, 1'b0);
        send_number(64'h800F_FFFF_FFFF_FFFF, 1'b1);
        send_number(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        for (int k = 0; k < 146; k++) begin
            if (k == 120) calm <= 1'b1;
            send_number(random_number(), 1'($urandom_range(1)));
        end
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
